### rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and codes for the LRU block cache.
// ----------------------------------------------------------------------------
package lbc_pkg;

	// operation codes carried in the mode field
	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_UPDATE = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISS     = 2'd1;
	localparam logic [1:0] ST_DISABLED = 2'd2;

	// entry key: disk number over block number
	localparam int KEY_W   = 12;
	localparam int STAMP_W = 32;
	localparam int CNT_W   = 32;
	localparam int CFG_W   = 7;
	localparam int WORD_W  = 64;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_SCAN,
		S_DECIDE,
		S_EMIT,
		S_RD,
		S_WR
	} lbc_state_t;

endpackage

### rtl/lru_block_cache_top.sv
// ----------------------------------------------------------------------------
// lru_block_cache_top
// Fully associative block cache with least-recently-used replacement.
// Tags, stamps and block words sit in synchronous memories; one sequencer
// scans the tag memory entry by entry and then reads or writes block words.
//
//  channel | direction | handshake           | payload
//  cfg     | in        | cfg_we              | cfg_wdata (entries in use)
//  in      | in        | in_valid / in_stall | mode, disk_number, block_number,
//          |           |                     | word_index, data_word
//  out     | out       | out_valid/out_stall | status, read_word, last,
//          |           |                     | hit_total, query_total
//
// One item at a time: in_stall stays high until the sequencer is idle. Lookup
// and insert/update at word 0 scan the tag memory at one entry a cycle; a
// lookup hit then streams the block, one memory read and one output load per
// word. After reset and after each cfg write taken while idle or clearing, a
// clearing pass over all MAX_ENTRIES entries resets the valid flags in the
// tag memory; in_stall is high meanwhile.
// A stalled output beat holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
module lru_block_cache_top
	import lbc_pkg::*;
#(
	parameter int MAX_ENTRIES = 64,
	parameter int WORDS       = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [3:0]        disk_number,
	input  logic [7:0]        block_number,
	input  logic [4:0]        word_index,
	input  logic [WORD_W-1:0] data_word,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [WORD_W-1:0] read_word,
	output logic              last,
	output logic [CNT_W-1:0]  hit_total,
	output logic [CNT_W-1:0]  query_total
);

	localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW   = $clog2(MAX_ENTRIES + 1);
	localparam int LW   = (CW > CFG_W) ? CW : CFG_W;
	localparam int DEP  = MAX_ENTRIES * WORDS;
	localparam int DAW  = $clog2(DEP);
	localparam int WCW  = $clog2(WORDS + 1);

	// memories
	logic [KEY_W:0]      tag_mem [MAX_ENTRIES];
	logic [STAMP_W-1:0]  stamp_mem [MAX_ENTRIES];
	logic [WORD_W-1:0]   data_mem [DEP];

	logic [KEY_W:0]      tag_rd;
	logic [STAMP_W-1:0]  stamp_rd;
	logic [WORD_W-1:0]   data_rd;

	// control state
	lbc_state_t          state_q, state_d;
	logic [CFG_W-1:0]    entries_q;
	logic [AW-1:0]       clr_q;
	logic [LW-1:0]       scan_q;
	logic                chk_s1;
	logic [AW-1:0]       idx_s1;
	logic                match_q, empty_q, min_ok_q;
	logic [AW-1:0]       match_idx_q, empty_idx_q, min_idx_q;
	logic [STAMP_W-1:0]  min_stamp_q;
	logic [STAMP_W-1:0]  clock_q;
	logic [CNT_W-1:0]    hits_q, queries_q;
	logic [AW-1:0]       wslot_q;
	logic                wok_q;
	logic [1:0]          res_q;
	logic [WCW-1:0]      word_q;
	logic                out_valid_q;

	// latched item
	logic [1:0]          mode_q;
	logic [KEY_W-1:0]    key_q;
	logic [WORD_W-1:0]   data_q;

	// combinational controls
	logic                accept, enabled, out_free, scan_issue, scan_done;
	logic                tag_we, stamp_we, data_we, data_re, out_load;
	logic [AW-1:0]       tag_wa, stamp_wa, slot_sel, rd_slot;
	logic [KEY_W:0]      tag_wd;
	logic [DAW-1:0]      data_wa, data_ra;
	logic [WORD_W-1:0]   data_wd;
	logic                word_last, hit_now;

	assign enabled   = (entries_q >= CFG_W'(2)) && (LW'(entries_q) <= LW'(MAX_ENTRIES));
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign scan_issue = (state_q == S_SCAN) && (scan_q < LW'(entries_q));
	assign scan_done = (state_q == S_SCAN) && !scan_issue && !chk_s1;
	assign word_last = (word_q == WCW'(WORDS - 1));
	assign hit_now   = match_q;
	assign in_stall  = (state_q != S_IDLE);

	// slot chosen at word 0: match, else first empty, else oldest
	always_comb begin
		priority if (match_q) begin
			slot_sel = match_idx_q;
		end else if (empty_q) begin
			slot_sel = empty_idx_q;
		end else begin
			slot_sel = min_idx_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cfg_we) begin
					state_d = S_CLEAR;
				end else if (accept && mode != MODE_NONE) begin
					priority if (!enabled) begin
						state_d = S_EMIT;
					end else if (mode == MODE_LOOKUP) begin
						state_d = S_SCAN;
					end else if (word_index == 5'd0) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_CLEAR: begin
				if (clr_q == AW'(MAX_ENTRIES - 1)) state_d = S_IDLE;
			end
			S_SCAN: begin
				if (scan_done) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (mode_q == MODE_LOOKUP && hit_now) begin
					state_d = S_RD;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) state_d = S_IDLE;
			end
			S_RD: begin
				state_d = S_WR;
			end
			S_WR: begin
				if (out_free) state_d = word_last ? S_IDLE : S_RD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory and output controls
	always_comb begin
		tag_we   = 1'b0;
		tag_wa   = clr_q;
		tag_wd   = '0;
		stamp_we = 1'b0;
		stamp_wa = slot_sel;
		data_we  = 1'b0;
		data_wa  = DAW'(wslot_q) * DAW'(WORDS) + DAW'(word_index);
		data_wd  = data_word;
		data_re  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				// later word of a block goes straight into the write target
				if (accept && !cfg_we && enabled && mode != MODE_NONE &&
				    mode != MODE_LOOKUP && word_index != 5'd0 &&
				    32'(word_index) < WORDS && wok_q) begin
					data_we = 1'b1;
				end
			end
			S_CLEAR: begin
				tag_we = 1'b1;
			end
			S_DECIDE: begin
				data_wa = DAW'(slot_sel) * DAW'(WORDS);
				data_wd = data_q;
				if (mode_q == MODE_LOOKUP) begin
					stamp_we = hit_now;
				end else if (mode_q == MODE_INSERT || hit_now) begin
					stamp_we = 1'b1;
					data_we  = 1'b1;
					if (!hit_now) begin
						tag_we = 1'b1;
						tag_wa = slot_sel;
						tag_wd = {1'b1, key_q};
					end
				end
			end
			S_EMIT: begin
				out_load = out_free;
			end
			S_RD: begin
				data_re = 1'b1;
			end
			S_WR: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	assign rd_slot = match_idx_q;
	assign data_ra = DAW'(rd_slot) * DAW'(WORDS) + DAW'(word_q);

	// tag memory
	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[tag_wa] <= tag_wd;
		if (scan_issue) tag_rd <= tag_mem[scan_q[AW-1:0]];
	end

	// stamp memory
	always_ff @(posedge clk) begin
		if (stamp_we) stamp_mem[stamp_wa] <= clock_q;
		if (scan_issue) stamp_rd <= stamp_mem[scan_q[AW-1:0]];
	end

	// block word memory
	always_ff @(posedge clk) begin
		if (data_we) data_mem[data_wa] <= data_wd;
		if (data_re) data_rd <= data_mem[data_ra];
	end

	// latched item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q  <= {disk_number, block_number};
			data_q <= data_word;
		end
	end

	// sequencer, scan and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			entries_q   <= '0;
			clr_q       <= '0;
			scan_q      <= '0;
			chk_s1      <= 1'b0;
			idx_s1      <= '0;
			match_q     <= 1'b0;
			empty_q     <= 1'b0;
			min_ok_q    <= 1'b0;
			match_idx_q <= '0;
			empty_idx_q <= '0;
			min_idx_q   <= '0;
			min_stamp_q <= '0;
			clock_q     <= '0;
			hits_q      <= '0;
			queries_q   <= '0;
			wslot_q     <= '0;
			wok_q       <= 1'b0;
			res_q       <= ST_OK;
			word_q      <= '0;
		end else begin
			state_q <= state_d;
			// config write sets entries in use, drops the write target and resets the clear index
			if (cfg_we) begin
				entries_q <= cfg_wdata;
				wok_q     <= 1'b0;
				wslot_q   <= '0;
				clr_q     <= '0;
			end else if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			// item accepted
			if (accept && !cfg_we && mode != MODE_NONE) begin
				scan_q   <= '0;
				match_q  <= 1'b0;
				empty_q  <= 1'b0;
				min_ok_q <= 1'b0;
				priority if (!enabled) begin
					res_q <= ST_DISABLED;
				end else if (mode == MODE_LOOKUP) begin
					clock_q   <= clock_q + 32'd1;
					queries_q <= queries_q + 32'd1;
				end else if (32'(word_index) >= WORDS) begin
					res_q <= ST_MISS;
				end else if (word_index != 5'd0) begin
					res_q <= wok_q ? ST_OK : ST_MISS;
				end
			end
			// scan pipeline: issue then compare
			chk_s1 <= scan_issue;
			idx_s1 <= scan_q[AW-1:0];
			if (scan_issue) scan_q <= scan_q + LW'(1);
			if (chk_s1) begin
				if (tag_rd[KEY_W] && tag_rd[KEY_W-1:0] == key_q && !match_q) begin
					match_q     <= 1'b1;
					match_idx_q <= idx_s1;
				end
				if (!tag_rd[KEY_W] && !empty_q) begin
					empty_q     <= 1'b1;
					empty_idx_q <= idx_s1;
				end
				if (tag_rd[KEY_W] && (!min_ok_q || stamp_rd < min_stamp_q)) begin
					min_ok_q    <= 1'b1;
					min_stamp_q <= stamp_rd;
					min_idx_q   <= idx_s1;
				end
			end
			// decision after the scan
			if (state_q == S_DECIDE) begin
				word_q <= '0;
				if (mode_q == MODE_LOOKUP) begin
					res_q <= hit_now ? ST_OK : ST_MISS;
					if (hit_now) hits_q <= hits_q + 32'd1;
				end else if (mode_q == MODE_INSERT || hit_now) begin
					res_q   <= ST_OK;
					wslot_q <= slot_sel;
					wok_q   <= 1'b1;
				end else begin
					res_q <= ST_MISS;
					wok_q <= 1'b0;
				end
			end
			if (state_q == S_WR && out_free) word_q <= word_q + WCW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_total   <= hits_q;
			query_total <= queries_q;
			if (state_q == S_WR) begin
				status    <= ST_OK;
				read_word <= data_rd;
				last      <= word_last;
			end else begin
				status    <= res_q;
				read_word <= '0;
				last      <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
